/* rtl/core/elf_segment_region_splitter_assert.svh */
// Assertion macros used by the region splitter RTL.
// ESR_ASSERT checks an implication in the same cycle; ESR_ASSERT_NXT checks it in the following cycle.
// Both are quiet while rst_n is low.
`ifndef ELF_SEGMENT_REGION_SPLITTER_ASSERT_SVH
`define ELF_SEGMENT_REGION_SPLITTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define ESR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ESR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ESR_ASSERT(label, ante, cons, msg)
`define ESR_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

/* rtl/core/esr_pkg.sv */
package esr_pkg;

  localparam int IDX_W = 4;

  // Program header types
  localparam logic [31:0] HDR_NULL    = 32'd0;
  localparam logic [31:0] HDR_LOAD    = 32'd1;
  localparam logic [31:0] HDR_DYNAMIC = 32'd2;
  localparam logic [31:0] HDR_INTERP  = 32'd3;
  localparam logic [31:0] HDR_NOTE    = 32'd4;
  localparam logic [31:0] HDR_SHLIB   = 32'd5;
  localparam logic [31:0] HDR_PHDR    = 32'd6;

  // Result kinds
  localparam logic [1:0] KIND_REGION   = 2'd0;
  localparam logic [1:0] KIND_DYNAMIC  = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [31:0] seg_type;
    logic [31:0] seg_vaddr;
    logic [31:0] seg_offset;
    logic [31:0] seg_filesz;
    logic [31:0] seg_memsz;
    logic        seg_writable;
    logic        last_header;
  } hdr_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [IDX_W-1:0] region_index;
    logic [31:0]      region_start;
    logic [31:0]      region_size;
    logic [31:0]      vm_start;
    logic [31:0]      vm_size;
    logic [31:0]      file_start;
    logic [31:0]      file_size;
    logic             anonymous;
    logic             writable;
    logic             last_result;
  } res_t;

  // Control from the region calculator to the sequencing logic
  typedef struct packed {
    logic emit;    // this phase produces a result word
    logic more;    // a second result word follows for the same header
    logic region;  // the result word consumes a region slot
  } calc_ctl_t;

endpackage

/* rtl/core/esr_region_calc.sv */
module esr_region_calc #(
  parameter int PAGE_SIZE   = 4096,
  parameter int MAX_REGIONS = 16,
  parameter int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
  input  esr_pkg::hdr_t      hdr,
  input  logic               phase,
  input  logic [CNT_W-1:0]   count,
  output esr_pkg::res_t      res,
  output esr_pkg::calc_ctl_t ctl
);
  import esr_pkg::*;

  localparam logic [31:0]      OFS_MASK = 32'(PAGE_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REGIONS);

  function automatic logic [31:0] page_down(input logic [31:0] x);
    return x & ~OFS_MASK;
  endfunction

  function automatic logic [31:0] page_up(input logic [31:0] x);
    return (x + OFS_MASK) & ~OFS_MASK;
  endfunction

  logic        is_load, is_dyn, is_unknown, split, tail, ovf;
  logic [31:0] poff, vms, vmz, vmz_all;

  assign is_load    = (hdr.seg_type == HDR_LOAD);
  assign is_dyn     = (hdr.seg_type == HDR_DYNAMIC);
  assign is_unknown = (hdr.seg_type > HDR_PHDR);
  assign poff       = hdr.seg_vaddr & OFS_MASK;
  assign vms        = page_down(hdr.seg_vaddr);
  assign vmz        = page_up(hdr.seg_filesz + poff);
  assign vmz_all    = page_up(hdr.seg_memsz + poff);
  assign split      = (hdr.seg_memsz != hdr.seg_filesz);
  // end of the zero-fill tail lies in a later page than the last file byte
  assign tail       = page_down(hdr.seg_vaddr + hdr.seg_memsz)
                      != page_down(hdr.seg_vaddr + hdr.seg_filesz - 32'd1);
  assign ovf        = (count >= CNT_MAX);

  assign ctl.emit   = is_load || is_dyn || is_unknown;
  assign ctl.more   = is_load && split && tail && !phase;
  assign ctl.region = is_load && !ovf;

  always_comb begin
    res             = '0;
    res.last_result = !ctl.more;
    if (is_load) begin
      if (ovf) begin
        res.result_kind = KIND_OVERFLOW;
      end else begin
        res.result_kind  = KIND_REGION;
        res.region_index = IDX_W'(count);
        res.region_start = hdr.seg_vaddr;
        res.writable     = hdr.seg_writable;
        if (!phase) begin
          // with equal sizes memsz and filesz agree, so one form serves both
          res.region_size = hdr.seg_filesz;
          res.vm_start    = vms;
          res.vm_size     = vmz;
          res.file_start  = hdr.seg_offset;
          res.file_size   = hdr.seg_filesz;
        end else begin
          res.region_size = hdr.seg_memsz - hdr.seg_filesz;
          res.vm_start    = vms + vmz;
          res.vm_size     = vmz_all - vmz;
          res.anonymous   = 1'b1;
        end
      end
    end else if (is_dyn) begin
      res.result_kind  = KIND_DYNAMIC;
      res.region_start = hdr.seg_vaddr;
    end else if (is_unknown) begin
      res.result_kind = KIND_UNKNOWN;
    end
  end

endmodule

/* rtl/core/esr_out_stage.sv */
module esr_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  esr_pkg::res_t d,
  output logic          free,
  output logic          out_valid,
  input  logic          out_stall,
  output esr_pkg::res_t out_word
);
  import esr_pkg::*;

  logic valid_r, valid_nxt;
  res_t word_r;

  // hold the word while stalled; take a new one once it has gone
  assign free      = !valid_r || !out_stall;
  assign valid_nxt = free ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      word_r <= d;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

/* rtl/core/elf_segment_region_splitter.sv */
// ELF32 program header to memory region splitter. Each input word is one program header; each
// output word is one result: a region descriptor, a dynamic section address, an unknown-type
// error or a region overflow, with last_result marking the final word for that header. A load
// segment with matching file and memory sizes gives one region; one with a zero-fill tail gives
// the file-backed region and, when the tail reaches a further page, an anonymous region mapped
// straight after it. Null, interp, note, shlib and phdr headers give no output word at all.
// A header passes through one input register and one output register: the region calculator
// works on the header in the input register and its result words are captured in the output
// register. The block takes one header per cycle while the output is not stalled; a split load
// segment with an anonymous tail holds the input register while the shared region calculator
// produces the second word. The region counter saturates at MAX_REGIONS and clears after a
// header flagged last_header.
// PAGE_SIZE must be a power of two.
`include "elf_segment_region_splitter_assert.svh"

module elf_segment_region_splitter #(
  parameter int PAGE_SIZE   = 4096,
  parameter int MAX_REGIONS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  esr_pkg::hdr_t in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output esr_pkg::res_t out_word
);
  import esr_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  // Input register: the header under work
  logic             a_valid_r, a_valid_nxt;
  hdr_t             a_hdr_r;
  // Phase: low for the first result word of a header, high for the anonymous tail
  logic             phase_r, phase_nxt;
  // Regions emitted in the current header table
  logic [CNT_W-1:0] count_r, count_nxt;

  res_t      calc_res;
  calc_ctl_t calc_ctl;
  logic      out_free, out_load, a_consume, a_take;

  esr_region_calc #(
    .PAGE_SIZE  (PAGE_SIZE),
    .MAX_REGIONS(MAX_REGIONS),
    .CNT_W      (CNT_W)
  ) u_calc (
    .hdr  (a_hdr_r),
    .phase(phase_r),
    .count(count_r),
    .res  (calc_res),
    .ctl  (calc_ctl)
  );

  esr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .d        (calc_res),
    .free     (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // Push a result word whenever the output register can take one.
  assign out_load  = a_valid_r && calc_ctl.emit && out_free;
  // Drop the header once its final word is pushed, or at once if it yields nothing.
  assign a_consume = a_valid_r && (!calc_ctl.emit || (out_free && !calc_ctl.more));
  assign in_stall  = a_valid_r && !a_consume;
  assign a_take    = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    if (!a_valid_r || a_consume) begin
      a_valid_nxt = in_valid;
    end
    if (out_load) begin
      phase_nxt = calc_ctl.more;
    end
    // End of table wins over a region taken by the same header.
    if (a_consume && a_hdr_r.last_header) begin
      count_nxt = '0;
    end else if (out_load && calc_ctl.region) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      phase_r   <= 1'b0;
      count_r   <= '0;
    end else begin
      a_valid_r <= a_valid_nxt;
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      a_hdr_r <= in_word;
    end
  end

  `ESR_ASSERT(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_REGIONS), "region count past limit")
  `ESR_ASSERT(a_phase_needs_hdr, phase_r, a_valid_r, "tail phase without a header")
  `ESR_ASSERT_NXT(a_phase_ends, phase_r && out_free, !phase_r, "tail phase did not close")

endmodule
